// ----- sv/lrm_pkg.sv -----
// line regex matcher package: sizes, character codes, command codes and item types
// shared by the cell, the result queue and the top level; no dependencies
`default_nettype none

package lrm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int CNT_W       = $clog2(PATTERN_MAX + 1);
	localparam int LINE_W      = 32;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_NL     = 8'h0A;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEXT   = 2'd2,
		CMD_END    = 2'd3
	} lrm_cmd_t;

	typedef struct packed {
		lrm_cmd_t    command;
		logic [7:0]  symbol;
	} lrm_in_t;

	typedef struct packed {
		logic              line_matched;
		logic [LINE_W-1:0] line_index;
		logic              unterminated;
	} lrm_out_t;

	// broadcast to every cell
	typedef struct packed {
		logic       step;
		logic       clear;
		logic [7:0] sym;
	} lrm_bcast_t;

	// per-cell selects from the top level
	typedef struct packed {
		logic tok_wr;
		logic star_set;
		logic inject;
		logic tok_valid;
		logic prev_valid;
	} lrm_cell_sel_t;

endpackage

`default_nettype wire

// ----- sv/lrm_cell.sv -----
// one position of the matcher row: a pattern token and its active bit
// depends on lrm_pkg
`default_nettype none

module lrm_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lrm_pkg::lrm_bcast_t   bc,
	input  wire lrm_pkg::lrm_cell_sel_t sel,
	input  wire logic                  close_in,
	input  wire logic                  fwd_in,
	output logic                       close_out,
	output logic                       fwd_out,
	output logic                       hit,
	output logic                       active
);
	import lrm_pkg::*;

	logic [7:0] tok_q;
	logic       star_q;
	logic       act_q;
	logic       cur;
	logic       acc;
	logic       act_next;

	always_comb begin
		cur       = act_q | sel.inject | close_in;
		acc       = (tok_q == CH_DOT) || (tok_q == bc.sym);
		close_out = cur & star_q & sel.tok_valid;
		fwd_out   = cur & sel.tok_valid & acc & ~star_q;
		act_next  = (cur & sel.tok_valid & acc & star_q) | fwd_in;
		hit       = cur & sel.prev_valid & ~sel.tok_valid;
		active    = act_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (bc.clear) begin
			act_q <= 1'b0;
		end else if (bc.step) begin
			act_q <= act_next;
		end
	end

	always_ff @(posedge clk) begin
		if (sel.tok_wr) begin
			tok_q  <= bc.sym;
			star_q <= 1'b0;
		end else if (sel.star_set) begin
			star_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- sv/lrm_out_fifo.sv -----
// two-entry result queue between the cell row and the result channel
// depends on lrm_pkg
`default_nettype none

module lrm_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lrm_pkg::lrm_out_t push_data,
	output logic                  full,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output lrm_pkg::lrm_out_t     result
);
	import lrm_pkg::*;

	lrm_out_t   ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	always_comb begin
		full         = (cnt_q == 2'd2);
		result_valid = (cnt_q != 2'd0);
		result       = ent_q[rd_q];
		pop          = result_valid & ~result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- sv/line_regex_matcher_core.sv -----
// line regex matcher top level: pattern loader, line control, cell row, result queue
// depends on lrm_pkg, lrm_cell, lrm_out_fifo
`default_nettype none

// Takes one item per clock: pattern edits, text characters and end of input. Each text
// character other than a newline updates a row of PATTERN_MAX+1 cells at once, one cell
// per pattern token plus the accept position, with star closure rippling from cell to
// cell. A newline, or end of input with a line open, places the line's result in a
// two-entry queue the cycle after the item is taken; items keep flowing while one result
// waits there, and the item side stalls only when both queue entries are full. The
// combinational cell row update sets the rate of one character per clock.
module line_regex_matcher_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire lrm_pkg::lrm_in_t item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output lrm_pkg::lrm_out_t     result
);
	import lrm_pkg::*;

	logic [CNT_W-1:0]  pcnt_q;
	logic [CNT_W-1:0]  ntok_q;
	logic              at_start_q;
	logic              at_end_q;
	logic              last_star_q;
	logic              line_open_q;
	logic              matched_q;
	logic [LINE_W-1:0] line_q;

	logic              fire;
	logic              is_nl;
	logic              do_clear;
	logic              do_append;
	logic              do_caret;
	logic              do_merge;
	logic              do_new;
	logic              step_evt;
	logic              close_evt;
	logic              fifo_full;
	logic              hit_any;
	logic [CNT_W-1:0]  tk_count;
	lrm_bcast_t        bc;
	lrm_out_t          push_data;

	lrm_cell_sel_t     sel     [PATTERN_MAX+1];
	logic [PATTERN_MAX+1:0] close_c;
	logic [PATTERN_MAX+1:0] fwd_c;
	logic [PATTERN_MAX:0]   hit_vec;
	logic [PATTERN_MAX:0]   act_vec;
	logic [PATTERN_MAX:0]   tok_valid;

	always_comb begin
		fire      = item_valid & ~item_stall;
		is_nl     = (item.symbol == CH_NL);
		do_clear  = 1'b0;
		do_append = 1'b0;
		step_evt  = 1'b0;
		close_evt = 1'b0;
		unique case (item.command)
			CMD_CLEAR: begin
				do_clear = fire & ~line_open_q;
			end
			CMD_APPEND: begin
				do_append = fire & ~line_open_q & (pcnt_q < CNT_W'(PATTERN_MAX));
			end
			CMD_TEXT: begin
				step_evt  = fire & ~is_nl;
				close_evt = fire & is_nl;
			end
			CMD_END: begin
				close_evt = fire & line_open_q;
			end
			default: begin
				do_clear = 1'b0;
			end
		endcase
		do_caret = do_append & (pcnt_q == '0) & (item.symbol == CH_CARET);
		do_merge = do_append & ~do_caret & (item.symbol == CH_STAR) &
			(ntok_q != '0) & ~last_star_q;
		do_new   = do_append & ~do_caret & ~do_merge;
		tk_count = ntok_q - CNT_W'(at_end_q);
		bc.step  = step_evt;
		bc.clear = close_evt;
		bc.sym   = item.symbol;
		hit_any  = |hit_vec;
		push_data.line_matched = matched_q | hit_any;
		push_data.line_index   = line_q;
		push_data.unterminated = (item.command == CMD_END);
		item_stall = fifo_full;
	end

	assign close_c[0] = 1'b0;
	assign fwd_c[0]   = 1'b0;

	for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_cell
		assign tok_valid[i] = (CNT_W'(i) < tk_count);
		always_comb begin
			sel[i].tok_wr     = do_new & (ntok_q == CNT_W'(i));
			sel[i].star_set   = do_merge & (ntok_q == CNT_W'(i + 1));
			sel[i].inject     = (i == 0) ? (~line_open_q | ~at_start_q) : 1'b0;
			sel[i].tok_valid  = tok_valid[i];
			sel[i].prev_valid = (i == 0) ? 1'b1 : tok_valid[(i == 0) ? 0 : i - 1];
		end
		lrm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bc        (bc),
			.sel       (sel[i]),
			.close_in  (close_c[i]),
			.fwd_in    (fwd_c[i]),
			.close_out (close_c[i+1]),
			.fwd_out   (fwd_c[i+1]),
			.hit       (hit_vec[i]),
			.active    (act_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			ntok_q      <= '0;
			at_start_q  <= 1'b0;
			at_end_q    <= 1'b0;
			last_star_q <= 1'b0;
			line_open_q <= 1'b0;
			matched_q   <= 1'b0;
			line_q      <= LINE_W'(1);
		end else begin
			if (do_clear) begin
				pcnt_q      <= '0;
				ntok_q      <= '0;
				at_start_q  <= 1'b0;
				at_end_q    <= 1'b0;
				last_star_q <= 1'b0;
			end
			if (do_append) begin
				pcnt_q <= pcnt_q + CNT_W'(1);
			end
			if (do_caret) begin
				at_start_q <= 1'b1;
			end
			if (do_merge) begin
				last_star_q <= 1'b1;
				at_end_q    <= 1'b0;
			end
			if (do_new) begin
				ntok_q      <= ntok_q + CNT_W'(1);
				last_star_q <= 1'b0;
				at_end_q    <= (item.symbol == CH_DOLLAR);
			end
			if (step_evt) begin
				line_open_q <= 1'b1;
				matched_q   <= matched_q | (~at_end_q & hit_any);
			end
			if (close_evt) begin
				line_open_q <= 1'b0;
				matched_q   <= 1'b0;
				if (line_q != '1) begin
					line_q <= line_q + LINE_W'(1);
				end
			end
		end
	end

	lrm_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (close_evt),
		.push_data    (push_data),
		.full         (fifo_full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_stall_only_when_results_wait: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item side stalled with no result waiting");

	a_idle_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!line_open_q |-> (act_vec == '0))
		else $error("active position outside an open line");

	a_match_needs_open_line: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q |-> line_open_q)
		else $error("match flag set with no open line");

	a_line_number_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(close_evt && line_q != '1) |=> (line_q == $past(line_q) + LINE_W'(1)))
		else $error("line number did not advance after a closed line");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for line_regex_matcher_core: random pattern and text streams with a
// line-by-line match predictor, random idling on both sides and a long result hold-off
// depends on lrm_pkg and line_regex_matcher_core
`timescale 1ns / 100ps

module tb_top;
	import lrm_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 1225;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	lrm_in_t  item         = '0;
	logic     item_stall;
	logic     result_valid;
	logic     result_stall = 1'b0;
	lrm_out_t result;

	line_regex_matcher_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// pattern and line state of the predictor
	logic [7:0]           pat_mem [PATTERN_MAX];
	int                   pat_len;
	logic [7:0]           tok_sym [PATTERN_MAX];
	bit                   tok_star [PATTERN_MAX];
	int                   tok_n;
	bit                   anchor_head;
	bit                   anchor_tail;
	logic [PATTERN_MAX:0] live;
	bit                   hit;
	logic [LINE_W-1:0]    line_no;
	bit                   in_line;

	lrm_in_t  pending_items [$];
	lrm_out_t lines_due [$];
	lrm_out_t want_line;

	int items_sent;
	int lines_checked;
	int unterm_checked;
	int err_count;
	int send_wait;
	int recv_wait;
	int hold_left;
	bit hold_done;
	bit no_gaps;
	bit no_stalls;
	int idle_cycles;
	bit timed_out;

	task automatic decode_pattern();
		int i;
		anchor_head = (pat_len > 0) && (pat_mem[0] == CH_CARET);
		anchor_tail = 1'b0;
		tok_n = 0;
		i = anchor_head ? 1 : 0;
		while (i < pat_len) begin
			if (i + 1 < pat_len && pat_mem[i + 1] == CH_STAR) begin
				tok_sym[tok_n]  = pat_mem[i];
				tok_star[tok_n] = 1'b1;
				tok_n++;
				i += 2;
			end else if (pat_mem[i] == CH_DOLLAR && i + 1 == pat_len) begin
				anchor_tail = 1'b1;
				i++;
			end else begin
				tok_sym[tok_n]  = pat_mem[i];
				tok_star[tok_n] = 1'b0;
				tok_n++;
				i++;
			end
		end
	endtask

	task automatic enter_position();
		if (!in_line) begin
			in_line = 1'b1;
			hit     = 1'b0;
			live    = '0;
			live[0] = 1'b1;
		end else if (!anchor_head) begin
			live[0] = 1'b1;
		end
		for (int k = 0; k < tok_n; k++)
			if (live[k] && tok_star[k])
				live[k + 1] = 1'b1;
		if (!anchor_tail && live[tok_n])
			hit = 1'b1;
	endtask

	task automatic advance_char(logic [7:0] c);
		logic [PATTERN_MAX:0] nxt;
		nxt = '0;
		for (int k = 0; k < tok_n; k++) begin
			if (live[k] && (tok_sym[k] == CH_DOT || tok_sym[k] == c)) begin
				if (tok_star[k])
					nxt[k] = 1'b1;
				else
					nxt[k + 1] = 1'b1;
			end
		end
		live = nxt;
	endtask

	task automatic close_line(bit unterm);
		lrm_out_t r;
		enter_position();
		if (anchor_tail && live[tok_n])
			hit = 1'b1;
		r.line_matched = hit;
		r.line_index   = line_no;
		r.unterminated = unterm;
		lines_due.push_back(r);
		if (line_no != '1)
			line_no++;
		in_line = 1'b0;
		hit     = 1'b0;
		live    = '0;
	endtask

	task automatic track_item(lrm_in_t it);
		case (it.command)
			CMD_CLEAR: begin
				if (!in_line)
					pat_len = 0;
			end
			CMD_APPEND: begin
				if (!in_line && pat_len < PATTERN_MAX) begin
					pat_mem[pat_len] = it.symbol;
					pat_len++;
				end
			end
			CMD_TEXT: begin
				decode_pattern();
				if (it.symbol == CH_NL) begin
					close_line(1'b0);
				end else begin
					enter_position();
					advance_char(it.symbol);
				end
			end
			default: begin
				if (in_line) begin
					decode_pattern();
					close_line(1'b1);
				end
			end
		endcase
	endtask

	task automatic queue_item(lrm_cmd_t c, logic [7:0] s);
		lrm_in_t it;
		it.command = c;
		it.symbol  = s;
		pending_items.push_back(it);
	endtask

	function automatic logic [7:0] pat_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return 8'h61 + 8'($urandom_range(0, 2));
		if (r < 11)
			return CH_DOT;
		if (r < 15)
			return CH_STAR;
		if (r == 15)
			return CH_CARET;
		if (r == 16)
			return CH_DOLLAR;
		if (r == 17)
			return CH_NL;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 19);
		if (r < 17)
			return 8'h61 + 8'($urandom_range(0, 2));
		if (r == 17)
			return CH_STAR;
		return 8'($urandom);
	endfunction

	task automatic queue_random_group();
		int n;
		int lines;
		int len;
		if ($urandom_range(0, 9) != 0)
			queue_item(CMD_CLEAR, 8'($urandom));
		if ($urandom_range(0, 2) == 0)
			queue_item(CMD_APPEND, CH_CARET);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 5);
		repeat (n) queue_item(CMD_APPEND, pat_char());
		if ($urandom_range(0, 2) == 0)
			queue_item(CMD_APPEND, CH_DOLLAR);
		lines = $urandom_range(1, 6);
		repeat (lines) begin
			len = $urandom_range(0, 10);
			for (int j = 0; j < len; j++) begin
				queue_item(CMD_TEXT, text_char());
				if ($urandom_range(0, 39) == 0)
					queue_item(lrm_cmd_t'($urandom_range(0, 3)), 8'($urandom));
			end
			if ($urandom_range(0, 6) == 0)
				queue_item(CMD_END, 8'($urandom));
			else
				queue_item(CMD_TEXT, CH_NL);
			if ($urandom_range(0, 9) == 0)
				queue_item(CMD_END, 8'($urandom));
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				track_item(item);
				items_sent++;
				if ($urandom_range(0, 99) == 0)
					no_gaps = !no_gaps;
				send_wait = no_gaps ? 0 : $urandom_range(0, 5);
			end
			if (!(item_valid && item_stall)) begin
				if (send_wait > 0) begin
					send_wait--;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (lines_due.size() == 0) begin
					$error("result with no line pending: line_index %0d", result.line_index);
					err_count++;
				end else begin
					want_line = lines_due.pop_front();
					if (result.line_matched !== want_line.line_matched) begin
						$error("line_matched: expected %0b, actual %0b",
							want_line.line_matched, result.line_matched);
						err_count++;
					end
					if (result.line_index !== want_line.line_index) begin
						$error("line_index: expected %0d, actual %0d",
							want_line.line_index, result.line_index);
						err_count++;
					end
					if (result.unterminated !== want_line.unterminated) begin
						$error("unterminated: expected %0b, actual %0b",
							want_line.unterminated, result.unterminated);
						err_count++;
					end
				end
				lines_checked++;
				if (result.unterminated)
					unterm_checked++;
				if ($urandom_range(0, 99) == 0)
					no_stalls = !no_stalls;
				recv_wait = no_stalls ? 0 : $urandom_range(0, 5);
			end
			if (!hold_done && lines_checked >= 60) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		pat_len = 0;
		live    = '0;
		hit     = 1'b0;
		line_no = 1;
		in_line = 1'b0;

		// end with nothing open, empty pattern on extreme bytes, empty line
		queue_item(CMD_END, 8'hFF);
		queue_item(CMD_TEXT, 8'h00);
		queue_item(CMD_TEXT, 8'hFF);
		queue_item(CMD_TEXT, CH_NL);
		queue_item(CMD_TEXT, CH_NL);
		// literal star after caret, anchored at both ends
		queue_item(CMD_CLEAR, 8'h00);
		queue_item(CMD_APPEND, CH_CARET);
		queue_item(CMD_APPEND, CH_STAR);
		queue_item(CMD_APPEND, "b");
		queue_item(CMD_APPEND, CH_DOLLAR);
		queue_item(CMD_TEXT, CH_STAR);
		queue_item(CMD_TEXT, "b");
		queue_item(CMD_TEXT, CH_NL);
		// edits ignored inside a line, closed by end
		queue_item(CMD_TEXT, "a");
		queue_item(CMD_APPEND, "x");
		queue_item(CMD_CLEAR, 8'hFF);
		queue_item(CMD_END, 8'h00);
		// star of a literal dollar, newline in pattern, zero byte in pattern
		queue_item(CMD_CLEAR, 8'h00);
		queue_item(CMD_APPEND, CH_DOLLAR);
		queue_item(CMD_APPEND, CH_STAR);
		queue_item(CMD_APPEND, 8'h00);
		queue_item(CMD_APPEND, CH_NL);
		queue_item(CMD_TEXT, 8'h00);
		queue_item(CMD_TEXT, CH_NL);
		queue_item(CMD_TEXT, "q");
		queue_item(CMD_END, 8'h00);

		while (pending_items.size() < ITEM_TARGET)
			queue_random_group();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		fork
			begin
				@(negedge clk);
				while (pending_items.size() != 0 || item_valid || lines_due.size() != 0)
					@(negedge clk);
				repeat (10) @(posedge clk);
			end
			begin
				while (idle_cycles < IDLE_LIMIT)
					@(posedge clk);
				timed_out = 1'b1;
			end
		join_any

		if (lines_due.size() != 0) begin
			$error("%0d predicted lines never came out", lines_due.size());
			err_count++;
		end

		$display("%0d items sent, %0d lines checked, %0d of them closed by end of input",
			items_sent, lines_checked, unterm_checked);
		if (!timed_out && err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/lrm_pkg.sv
sv/lrm_cell.sv
sv/lrm_out_fifo.sv
sv/line_regex_matcher_core.sv
test/tb_top.sv
